### rtl/lmcfe_pkg.sv
// ============================================================================
// lmcfe_pkg
// Shared types, constants and helper functions for the LED matrix chain
// frame engine.
// ============================================================================
package lmcfe_pkg;

  // Number of displays in the daisy chain.
  localparam int CHAIN_LENGTH = 2;

  // Field widths of the request and result channels.
  localparam int ACT_W  = 3;
  localparam int DEV_W  = 2;
  localparam int ROW_W  = 4;
  localparam int COL_W  = 4;
  localparam int BYTE_W = 8;
  localparam int CFG_W  = 2;

  // Row store geometry: eight row bytes per display.
  localparam int ROWS        = 8;
  localparam int ROW_IDX_W   = $clog2(ROWS);
  localparam int STORE_DEPTH = CHAIN_LENGTH * ROWS;
  localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

  // Bytes in one frame: opcode and data for every chain slot.
  localparam int FRAME_BYTES = 2 * CHAIN_LENGTH;
  localparam int FBYTE_W     = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;

  // Frames per device during init.
  localparam int INIT_STEPS = 5;
  localparam int STEP_W     = 3;

  localparam logic [CFG_W-1:0] ACTIVE_RESET = CFG_W'(2);

  // Display driver opcodes.
  localparam logic [BYTE_W-1:0] OP_DECODE     = 8'd9;
  localparam logic [BYTE_W-1:0] OP_INTENSITY  = 8'd10;
  localparam logic [BYTE_W-1:0] OP_SCAN_LIMIT = 8'd11;
  localparam logic [BYTE_W-1:0] OP_POWER      = 8'd12;
  localparam logic [BYTE_W-1:0] OP_TEST       = 8'd15;

  localparam logic [BYTE_W-1:0] SCAN_ALL_ROWS  = 8'd7;
  localparam logic [BYTE_W-1:0] INIT_INTENSITY = 8'd4;
  localparam logic [BYTE_W-1:0] POWER_ON       = 8'd1;
  localparam logic [BYTE_W-1:0] PIXEL_MSB      = 8'h80;

  typedef enum logic [ACT_W-1:0] {
    ACT_SET_PIXEL = 3'd0,
    ACT_SET_ROW   = 3'd1,
    ACT_CLEAR_DEV = 3'd2,
    ACT_INTENSITY = 3'd3,
    ACT_INIT      = 3'd4
  } lmcfe_action_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_EMIT
  } lmcfe_state_t;

  // Access to the row store from the sequencer.
  typedef struct packed {
    logic                rd_en;
    logic                wr_en;
    logic [ADDR_W-1:0]   addr;
    logic [BYTE_W-1:0]   wr_data;
    logic                clr_dev_en;
    logic [DEV_W-1:0]    clr_dev;
    logic                clr_all;
  } lmcfe_store_req_t;

  // One serial byte leaving the sequencer.
  typedef struct packed {
    logic [BYTE_W-1:0] spi_byte;
    logic              frame_end;
    logic              last;
  } lmcfe_emit_t;

  // Opcode of each init step.
  function automatic logic [BYTE_W-1:0] init_op(input logic [STEP_W-1:0] step);
    logic [BYTE_W-1:0] op;
    case (step)
      3'd0:    op = OP_TEST;
      3'd1:    op = OP_SCAN_LIMIT;
      3'd2:    op = OP_DECODE;
      3'd3:    op = OP_INTENSITY;
      default: op = OP_POWER;
    endcase
    return op;
  endfunction

  // Data byte of each init step.
  function automatic logic [BYTE_W-1:0] init_data(input logic [STEP_W-1:0] step);
    logic [BYTE_W-1:0] d;
    case (step)
      3'd1:    d = SCAN_ALL_ROWS;
      3'd3:    d = INIT_INTENSITY;
      3'd4:    d = POWER_ON;
      default: d = '0;
    endcase
    return d;
  endfunction

endpackage

### rtl/lmcfe_in_if.sv
// ============================================================================
// lmcfe_in_if
// Request channel: one display command per handshake.
// ============================================================================
interface lmcfe_in_if;
  logic                             valid;
  logic                             ready;
  logic [lmcfe_pkg::ACT_W-1:0]      action;
  logic [lmcfe_pkg::DEV_W-1:0]      device;
  logic [lmcfe_pkg::ROW_W-1:0]      row;
  logic [lmcfe_pkg::COL_W-1:0]      col;
  logic                             pixel_on;
  logic [lmcfe_pkg::BYTE_W-1:0]     data_value;

  modport source (output valid, action, device, row, col, pixel_on, data_value,
                  input ready);
  modport sink   (input valid, action, device, row, col, pixel_on, data_value,
                  output ready);
endinterface

### rtl/lmcfe_out_if.sv
// ============================================================================
// lmcfe_out_if
// Result channel: one serial byte per handshake.
// ============================================================================
interface lmcfe_out_if;
  logic                         valid;
  logic                         ready;
  logic [lmcfe_pkg::BYTE_W-1:0] spi_byte;
  logic                         frame_end;
  logic                         last;

  modport source (output valid, spi_byte, frame_end, last, input ready);
  modport sink   (input valid, spi_byte, frame_end, last, output ready);
endinterface

### rtl/lmcfe_row_store.sv
// ============================================================================
// lmcfe_row_store
// Shadow store of the row bytes with a registered read and per-entry valid
// bits; an entry that is not valid reads as zero.
// ============================================================================
module lmcfe_row_store (
  input  logic                           clk,
  input  logic                           rst_n,
  input  lmcfe_pkg::lmcfe_store_req_t    req,
  output logic [lmcfe_pkg::BYTE_W-1:0]   rd_data
);

  logic [lmcfe_pkg::BYTE_W-1:0]      mem [lmcfe_pkg::STORE_DEPTH];
  logic [lmcfe_pkg::STORE_DEPTH-1:0] vld_r;
  logic [lmcfe_pkg::BYTE_W-1:0]      rd_data_r;
  logic                              rd_vld_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data_r <= mem[req.addr];
    end
  end

  // Clearing only drops valid bits, so a whole device or the whole store
  // empties together, without a walk over the entries.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      for (int i = 0; i < lmcfe_pkg::STORE_DEPTH; i++) begin
        if (req.clr_all) begin
          vld_r[i] <= 1'b0;
        end else if (req.clr_dev_en && ((i / lmcfe_pkg::ROWS) == int'(req.clr_dev))) begin
          vld_r[i] <= 1'b0;
        end else if (req.wr_en && (req.addr == lmcfe_pkg::ADDR_W'(i))) begin
          vld_r[i] <= 1'b1;
        end
      end
      if (req.rd_en) begin
        rd_vld_r <= vld_r[req.addr];
      end
    end
  end

  assign rd_data = rd_vld_r ? rd_data_r : '0;

endmodule

### rtl/lmcfe_sequencer.sv
// ============================================================================
// lmcfe_sequencer
// Decodes commands, drives the row store and walks the frames of a command
// one serial byte per cycle while the output takes them.
// ============================================================================
module lmcfe_sequencer (
  input  logic                          clk,
  input  logic                          rst_n,
  lmcfe_in_if.sink                      in_ch,
  input  logic [lmcfe_pkg::CFG_W-1:0]   active_cnt,
  output lmcfe_pkg::lmcfe_store_req_t   store_req,
  input  logic [lmcfe_pkg::BYTE_W-1:0]  rd_data,
  output logic                          emit_valid,
  input  logic                          emit_take,
  output lmcfe_pkg::lmcfe_emit_t        emit
);

  lmcfe_pkg::lmcfe_state_t            state_r, state_nxt;
  lmcfe_pkg::lmcfe_action_t           kind_r, kind_nxt;
  logic [lmcfe_pkg::DEV_W-1:0]        dev_r, dev_nxt;
  logic [lmcfe_pkg::ROW_IDX_W-1:0]    row_r, row_nxt;
  logic [lmcfe_pkg::BYTE_W-1:0]       data_r, data_nxt;
  logic [lmcfe_pkg::BYTE_W-1:0]       mask_r, mask_nxt;
  logic                               on_r, on_nxt;
  logic [lmcfe_pkg::ADDR_W-1:0]       addr_r, addr_nxt;
  logic [lmcfe_pkg::FBYTE_W-1:0]      byte_r, byte_nxt;
  logic [lmcfe_pkg::STEP_W-1:0]       frame_r, frame_nxt;
  logic [lmcfe_pkg::DEV_W-1:0]        init_dev_r, init_dev_nxt;
  logic [lmcfe_pkg::DEV_W-1:0]        init_cnt_r, init_cnt_nxt;

  logic                               dev_ok, row_ok, col_ok;
  logic [lmcfe_pkg::ADDR_W-1:0]       in_addr;
  logic [lmcfe_pkg::DEV_W-1:0]        cnt_sat;
  logic [lmcfe_pkg::BYTE_W-1:0]       rmw_data;

  // Fields of the frame now being sent.
  logic [lmcfe_pkg::DEV_W-1:0]        f_dev;
  logic [lmcfe_pkg::BYTE_W-1:0]       f_op, f_data;
  logic                               f_last;
  logic [lmcfe_pkg::DEV_W-1:0]        slot;
  logic                               frame_end;

  assign dev_ok  = in_ch.device < lmcfe_pkg::DEV_W'(lmcfe_pkg::CHAIN_LENGTH);
  assign row_ok  = in_ch.row < lmcfe_pkg::ROW_W'(lmcfe_pkg::ROWS);
  assign col_ok  = in_ch.col < lmcfe_pkg::COL_W'(lmcfe_pkg::ROWS);
  assign in_addr = lmcfe_pkg::ADDR_W'({in_ch.device, in_ch.row[lmcfe_pkg::ROW_IDX_W-1:0]});
  assign cnt_sat = (active_cnt > lmcfe_pkg::CFG_W'(lmcfe_pkg::CHAIN_LENGTH))
                   ? lmcfe_pkg::DEV_W'(lmcfe_pkg::CHAIN_LENGTH)
                   : lmcfe_pkg::DEV_W'(active_cnt);
  assign rmw_data = on_r ? (rd_data | mask_r) : (rd_data & ~mask_r);

  always_comb begin
    f_dev  = dev_r;
    f_op   = {5'd0, row_r} + 8'd1;
    f_data = data_r;
    f_last = 1'b1;
    case (kind_r)
      lmcfe_pkg::ACT_CLEAR_DEV: begin
        f_op   = {5'd0, frame_r} + 8'd1;
        f_data = '0;
        f_last = frame_r == lmcfe_pkg::STEP_W'(lmcfe_pkg::ROWS - 1);
      end
      lmcfe_pkg::ACT_INTENSITY: begin
        f_op = lmcfe_pkg::OP_INTENSITY;
      end
      lmcfe_pkg::ACT_INIT: begin
        f_dev  = init_dev_r;
        f_op   = lmcfe_pkg::init_op(frame_r);
        f_data = lmcfe_pkg::init_data(frame_r);
        f_last = (frame_r == lmcfe_pkg::STEP_W'(lmcfe_pkg::INIT_STEPS - 1)) &&
                 (init_dev_r == lmcfe_pkg::DEV_W'(init_cnt_r - lmcfe_pkg::DEV_W'(1)));
      end
      default: ;
    endcase
  end

  // The farthest slot goes first; bit 0 of the byte count picks data over opcode.
  assign slot = lmcfe_pkg::DEV_W'(lmcfe_pkg::CHAIN_LENGTH - 1) -
                lmcfe_pkg::DEV_W'(byte_r >> 1);
  assign frame_end = byte_r == lmcfe_pkg::FBYTE_W'(lmcfe_pkg::FRAME_BYTES - 1);

  assign emit_valid     = state_r == lmcfe_pkg::ST_EMIT;
  assign emit.spi_byte  = (slot == f_dev) ? (byte_r[0] ? f_data : f_op) : '0;
  assign emit.frame_end = frame_end;
  assign emit.last      = frame_end && f_last;

  always_comb begin
    state_nxt    = state_r;
    kind_nxt     = kind_r;
    dev_nxt      = dev_r;
    row_nxt      = row_r;
    data_nxt     = data_r;
    mask_nxt     = mask_r;
    on_nxt       = on_r;
    addr_nxt     = addr_r;
    byte_nxt     = byte_r;
    frame_nxt    = frame_r;
    init_dev_nxt = init_dev_r;
    init_cnt_nxt = init_cnt_r;
    store_req    = '0;
    in_ch.ready  = 1'b0;

    unique case (state_r)
      lmcfe_pkg::ST_IDLE: begin
        in_ch.ready  = 1'b1;
        byte_nxt     = '0;
        frame_nxt    = '0;
        init_dev_nxt = '0;
        if (in_ch.valid) begin
          kind_nxt = lmcfe_pkg::lmcfe_action_t'(in_ch.action);
          dev_nxt  = in_ch.device;
          row_nxt  = in_ch.row[lmcfe_pkg::ROW_IDX_W-1:0];
          data_nxt = in_ch.data_value;
          mask_nxt = lmcfe_pkg::PIXEL_MSB >> in_ch.col[lmcfe_pkg::ROW_IDX_W-1:0];
          on_nxt   = in_ch.pixel_on;
          addr_nxt = in_addr;
          unique case (in_ch.action)
            lmcfe_pkg::ACT_SET_PIXEL: begin
              if (dev_ok && row_ok && col_ok) begin
                store_req.rd_en = 1'b1;
                store_req.addr  = in_addr;
                state_nxt       = lmcfe_pkg::ST_READ;
              end
            end
            lmcfe_pkg::ACT_SET_ROW: begin
              if (dev_ok && row_ok) begin
                store_req.wr_en   = 1'b1;
                store_req.addr    = in_addr;
                store_req.wr_data = in_ch.data_value;
                state_nxt         = lmcfe_pkg::ST_EMIT;
              end
            end
            lmcfe_pkg::ACT_CLEAR_DEV: begin
              if (dev_ok) begin
                store_req.clr_dev_en = 1'b1;
                store_req.clr_dev    = in_ch.device;
                state_nxt            = lmcfe_pkg::ST_EMIT;
              end
            end
            lmcfe_pkg::ACT_INTENSITY: begin
              if (dev_ok) begin
                state_nxt = lmcfe_pkg::ST_EMIT;
              end
            end
            lmcfe_pkg::ACT_INIT: begin
              store_req.clr_all = 1'b1;
              init_cnt_nxt      = cnt_sat;
              if (cnt_sat != '0) begin
                state_nxt = lmcfe_pkg::ST_EMIT;
              end
            end
            default: ;
          endcase
        end
      end

      lmcfe_pkg::ST_READ: begin
        store_req.wr_en   = 1'b1;
        store_req.addr    = addr_r;
        store_req.wr_data = rmw_data;
        data_nxt          = rmw_data;
        state_nxt         = lmcfe_pkg::ST_EMIT;
      end

      lmcfe_pkg::ST_EMIT: begin
        if (emit_take) begin
          if (!frame_end) begin
            byte_nxt = byte_r + lmcfe_pkg::FBYTE_W'(1);
          end else begin
            byte_nxt = '0;
            if (f_last) begin
              state_nxt = lmcfe_pkg::ST_IDLE;
            end else if ((kind_r == lmcfe_pkg::ACT_INIT) &&
                         (frame_r == lmcfe_pkg::STEP_W'(lmcfe_pkg::INIT_STEPS - 1))) begin
              frame_nxt    = '0;
              init_dev_nxt = init_dev_r + lmcfe_pkg::DEV_W'(1);
            end else begin
              frame_nxt = frame_r + lmcfe_pkg::STEP_W'(1);
            end
          end
        end
      end

      default: state_nxt = lmcfe_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lmcfe_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r     <= kind_nxt;
    dev_r      <= dev_nxt;
    row_r      <= row_nxt;
    data_r     <= data_nxt;
    mask_r     <= mask_nxt;
    on_r       <= on_nxt;
    addr_r     <= addr_nxt;
    byte_r     <= byte_nxt;
    frame_r    <= frame_nxt;
    init_dev_r <= init_dev_nxt;
    init_cnt_r <= init_cnt_nxt;
  end

endmodule

### rtl/led_matrix_chain_frame_engine.sv
// ============================================================================
// led_matrix_chain_frame_engine
// Command front end for a daisy chain of 8x8 LED matrix drivers: keeps a
// shadow of every row and turns each command into serial frames.
// ============================================================================
//
//   Channel   Direction  Carries
//   in_ch     sink       one command: action, device, row, col, pixel_on,
//                        data_value
//   out_ch    source     one serial byte: spi_byte, frame_end, last
//   cfg_*     write-only active_devices, the number of displays init sets up
//
// A command is taken in one handshake; its bytes then leave in four-byte frames,
// one per cycle while the sink takes them. Set pixel first reads the row store.
// Set row and set intensity send one frame, clear device eight, init five per
// active display (up to ten). The sequencer handles one command at a time.
// Reset is synchronous and active low; the valid bits empty the row store.
// A stalled result holds the output register and stops the frame walk.
// ============================================================================
module led_matrix_chain_frame_engine (
  input  logic                         clk,
  input  logic                         rst_n,
  lmcfe_in_if.sink                     in_ch,
  lmcfe_out_if.source                  out_ch,
  input  logic                         cfg_we,
  input  logic [lmcfe_pkg::CFG_W-1:0]  cfg_wdata
);

  logic [lmcfe_pkg::CFG_W-1:0]      active_r;
  lmcfe_pkg::lmcfe_store_req_t      store_req;
  logic [lmcfe_pkg::BYTE_W-1:0]     rd_data;
  logic                             emit_valid;
  logic                             emit_take;
  lmcfe_pkg::lmcfe_emit_t           emit;

  logic                             out_valid_r;
  logic [lmcfe_pkg::BYTE_W-1:0]     out_byte_r;
  logic                             out_frame_end_r;
  logic                             out_last_r;

  // The configuration register; the user must write it only while the block is idle (not enforced here).
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= lmcfe_pkg::ACTIVE_RESET;
    end else if (cfg_we) begin
      active_r <= cfg_wdata;
    end
  end

  lmcfe_row_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (store_req),
    .rd_data (rd_data)
  );

  lmcfe_sequencer u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .active_cnt (active_r),
    .store_req  (store_req),
    .rd_data    (rd_data),
    .emit_valid (emit_valid),
    .emit_take  (emit_take),
    .emit       (emit)
  );

  // Output register: it loads whenever it is empty or its byte is being
  // taken, so a steady sink sees one byte per cycle while a command is sent.
  assign emit_take = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_take) begin
      out_valid_r <= emit_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_take && emit_valid) begin
      out_byte_r      <= emit.spi_byte;
      out_frame_end_r <= emit.frame_end;
      out_last_r      <= emit.last;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.spi_byte  = out_byte_r;
  assign out_ch.frame_end = out_frame_end_r;
  assign out_ch.last      = out_last_r;

`ifndef SYNTHESIS
  // The final byte of a command always closes a frame.
  a_last_ends_frame: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_last_r |-> out_frame_end_r)
    else $error("last byte does not close a frame");

  // While bytes of a command are still to come, no new request is taken.
  a_busy_until_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_last_r |-> !in_ch.ready)
    else $error("request taken in the middle of a command");

  // The byte stream of a command has no bubbles behind a non-final byte.
  a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_last_r |=> out_valid_r)
    else $error("gap inside a command's byte stream");
`endif

endmodule

### bench/testbench.sv
// ============================================================================
// testbench
// Self-checking bench for the LED matrix chain frame engine. A frame tracker
// class keeps its own shadow of the row store and the active display count.
// It expands every accepted request into the serial bytes it must produce,
// and then checks each byte that leaves the block against the oldest one
// still owed. Requests come in random bursts. The byte sink stalls on
// patterns of its own and holds off once for a long stretch.
// ============================================================================
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // Columns per display; the pixel mask walks down from the top bit.
  localparam int COLS = 8;

  // Action codes that the block has no meaning for and must ignore.
  localparam logic [lmcfe_pkg::ACT_W-1:0] ACT_SPARE_A = 3'd5;
  localparam logic [lmcfe_pkg::ACT_W-1:0] ACT_SPARE_B = 3'd6;
  localparam logic [lmcfe_pkg::ACT_W-1:0] ACT_SPARE_C = 3'd7;

  // The block takes a request and then flushes the last byte through its output
  // register, so this many quiet cycles after the last owed byte is ample.
  localparam int DRAIN_SLACK = 16;

  // The sink refuses every byte for this long once, so that the block fills
  // up and pushes back on the request channel.
  localparam int LONG_HOLD = 300;

  // Worst case: about 110 requests of 40 bytes each, with the sink taking
  // one byte in four, plus the long hold. This limit is far above that.
  localparam int CYCLE_LIMIT = 400000;

  // Random requests that produce bytes, per configuration phase.
  localparam int PHASE_REQUESTS = 17;

  // One display command as it crosses the request channel.
  typedef struct packed {
    logic [lmcfe_pkg::ACT_W-1:0]  action;
    logic [lmcfe_pkg::DEV_W-1:0]  device;
    logic [lmcfe_pkg::ROW_W-1:0]  row;
    logic [lmcfe_pkg::COL_W-1:0]  col;
    logic                         pixel_on;
    logic [lmcfe_pkg::BYTE_W-1:0] data_value;
  } display_cmd_t;

  // Patterns that the byte sink cycles through.
  typedef enum logic [1:0] {
    SINK_OPEN,
    SINK_COIN,
    SINK_SPARSE,
    SINK_PERIODIC
  } sink_mode_t;

  // --------------------------------------------------------------------------
  // Frame tracker: a shadow of the row store plus the queue of owed bytes.
  // --------------------------------------------------------------------------
  class frame_tracker;
    lmcfe_pkg::lmcfe_emit_t       owed_bytes[$];
    logic [lmcfe_pkg::BYTE_W-1:0] shadow_rows[lmcfe_pkg::STORE_DEPTH];
    logic [lmcfe_pkg::CFG_W-1:0]  active_devices;
    int                           mismatch_count;
    int                           bytes_seen;

    function new();
      foreach (shadow_rows[i]) shadow_rows[i] = '0;
      active_devices = lmcfe_pkg::ACTIVE_RESET;
      mismatch_count = 0;
      bytes_seen     = 0;
    endfunction

    function void set_active(logic [lmcfe_pkg::CFG_W-1:0] count);
      active_devices = count;
    endfunction

    // The count is clipped to the chain length.
    function int displays_to_init();
      return (int'(active_devices) > lmcfe_pkg::CHAIN_LENGTH)
             ? lmcfe_pkg::CHAIN_LENGTH : int'(active_devices);
    endfunction

    function bit yields_output(display_cmd_t c);
      bit in_chain;
      in_chain = int'(c.device) < lmcfe_pkg::CHAIN_LENGTH;
      case (c.action)
        lmcfe_pkg::ACT_SET_PIXEL:
          return in_chain && int'(c.row) < lmcfe_pkg::ROWS && int'(c.col) < COLS;
        lmcfe_pkg::ACT_SET_ROW:   return in_chain && int'(c.row) < lmcfe_pkg::ROWS;
        lmcfe_pkg::ACT_CLEAR_DEV: return in_chain;
        lmcfe_pkg::ACT_INTENSITY: return in_chain;
        lmcfe_pkg::ACT_INIT:      return displays_to_init() > 0;
        default:                  return 1'b0;
      endcase
    endfunction

    // The farthest slot goes first, and slots that are not targeted get zeros.
    function void push_frame(int target, logic [lmcfe_pkg::BYTE_W-1:0] opcode,
                             logic [lmcfe_pkg::BYTE_W-1:0] data);
      lmcfe_pkg::lmcfe_emit_t b;
      for (int slot = lmcfe_pkg::CHAIN_LENGTH - 1; slot >= 0; slot--) begin
        b.spi_byte  = (slot == target) ? opcode : '0;
        b.frame_end = 1'b0;
        b.last      = 1'b0;
        owed_bytes.push_back(b);
        b.spi_byte  = (slot == target) ? data : '0;
        b.frame_end = (slot == 0);
        owed_bytes.push_back(b);
      end
    endfunction

    function void take_command(display_cmd_t c);
      int                           idx;
      int                           queued;
      logic [lmcfe_pkg::BYTE_W-1:0] mask;
      lmcfe_pkg::lmcfe_emit_t       tail;
      queued = owed_bytes.size();
      idx    = int'(c.device) * lmcfe_pkg::ROWS + int'(c.row);
      case (c.action)
        lmcfe_pkg::ACT_SET_PIXEL: begin
          if (yields_output(c)) begin
            mask = lmcfe_pkg::PIXEL_MSB >> c.col;
            if (c.pixel_on) begin
              shadow_rows[idx] = shadow_rows[idx] | mask;
            end else begin
              shadow_rows[idx] = shadow_rows[idx] & ~mask;
            end
            push_frame(int'(c.device), lmcfe_pkg::BYTE_W'(c.row) + 8'd1,
                       shadow_rows[idx]);
          end
        end
        lmcfe_pkg::ACT_SET_ROW: begin
          if (yields_output(c)) begin
            shadow_rows[idx] = c.data_value;
            push_frame(int'(c.device), lmcfe_pkg::BYTE_W'(c.row) + 8'd1,
                       c.data_value);
          end
        end
        lmcfe_pkg::ACT_CLEAR_DEV: begin
          if (yields_output(c)) begin
            for (int r = 0; r < lmcfe_pkg::ROWS; r++) begin
              shadow_rows[int'(c.device) * lmcfe_pkg::ROWS + r] = '0;
              push_frame(int'(c.device), lmcfe_pkg::BYTE_W'(r + 1), '0);
            end
          end
        end
        lmcfe_pkg::ACT_INTENSITY: begin
          if (yields_output(c))
            push_frame(int'(c.device), lmcfe_pkg::OP_INTENSITY, c.data_value);
        end
        lmcfe_pkg::ACT_INIT: begin
          foreach (shadow_rows[i]) shadow_rows[i] = '0;
          for (int d = 0; d < displays_to_init(); d++) begin
            push_frame(d, lmcfe_pkg::OP_TEST, '0);
            push_frame(d, lmcfe_pkg::OP_SCAN_LIMIT, lmcfe_pkg::SCAN_ALL_ROWS);
            push_frame(d, lmcfe_pkg::OP_DECODE, '0);
            push_frame(d, lmcfe_pkg::OP_INTENSITY, lmcfe_pkg::INIT_INTENSITY);
            push_frame(d, lmcfe_pkg::OP_POWER, lmcfe_pkg::POWER_ON);
          end
        end
        default: ;
      endcase
      if (owed_bytes.size() > queued) begin
        tail      = owed_bytes.pop_back();
        tail.last = 1'b1;
        owed_bytes.push_back(tail);
      end
    endfunction

    task report_mismatch(string what);
      $display("[%0t] mismatch: %s", $time, what);
      mismatch_count++;
    endtask

    task match_byte(lmcfe_pkg::lmcfe_emit_t got);
      lmcfe_pkg::lmcfe_emit_t want;
      bytes_seen++;
      if (owed_bytes.size() == 0) begin
        report_mismatch($sformatf("byte %0d (0x%02h) arrived with nothing owed",
                                  bytes_seen, got.spi_byte));
        return;
      end
      want = owed_bytes.pop_front();
      if (got.spi_byte !== want.spi_byte)
        report_mismatch($sformatf("byte %0d spi_byte 0x%02h, want 0x%02h",
                                  bytes_seen, got.spi_byte, want.spi_byte));
      if (got.frame_end !== want.frame_end)
        report_mismatch($sformatf("byte %0d frame_end %b, want %b",
                                  bytes_seen, got.frame_end, want.frame_end));
      if (got.last !== want.last)
        report_mismatch($sformatf("byte %0d last %b, want %b",
                                  bytes_seen, got.last, want.last));
    endtask
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, channels and the block itself.
  // --------------------------------------------------------------------------
  logic                        clk = 1'b0;
  logic                        rst_n;
  logic                        cfg_we;
  logic [lmcfe_pkg::CFG_W-1:0] cfg_wdata;

  int           hold_cycles_left = 0;
  int           cycle_count = 0;
  int           burst_left = 0;
  frame_tracker tracker;

  lmcfe_in_if  cmd_ch ();
  lmcfe_out_if byte_ch ();

  always #10 clk = ~clk;

  led_matrix_chain_frame_engine i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (cmd_ch),
    .out_ch    (byte_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // --------------------------------------------------------------------------
  // Monitor. Everything is sampled at the rising edge, before the block's own
  // registers update, so what is seen here is exactly what the block saw.
  // The configuration write, the accepted request and the accepted byte of one
  // edge are handled in that order. A byte can never belong to a request
  // accepted at the same edge, because the output is registered.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && cfg_we) tracker.set_active(cfg_wdata);
    if (rst_n && cmd_ch.valid && cmd_ch.ready)
      tracker.take_command(display_cmd_t'({cmd_ch.action, cmd_ch.device, cmd_ch.row,
                                           cmd_ch.col, cmd_ch.pixel_on,
                                           cmd_ch.data_value}));
    if (rst_n && byte_ch.valid && byte_ch.ready)
      tracker.match_byte(lmcfe_pkg::lmcfe_emit_t'({byte_ch.spi_byte,
                                                   byte_ch.frame_end,
                                                   byte_ch.last}));
  end

  // The watchdog ends a run that has hung, for example on a lost byte.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d bytes still owed",
               cycle_count, tracker.owed_bytes.size());
      $display("led_matrix_chain_frame_engine regression: fail");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Byte sink. It switches between patterns at random: always ready, a coin
  // toss, mostly stalled, and ready on ticks that are a multiple of three. When
  // the main sequence asks for a long hold, it counts that hold down here,
  // in its own process, and refuses every byte until the count runs out.
  // --------------------------------------------------------------------------
  initial begin
    sink_mode_t mode;
    int         mode_left;
    int         tick;
    mode      = SINK_OPEN;
    mode_left = 0;
    tick      = 0;
    byte_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      tick++;
      if (hold_cycles_left > 0) begin
        hold_cycles_left--;
        byte_ch.ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = sink_mode_t'($urandom_range(0, 3));
          mode_left = $urandom_range(20, 80);
        end
        mode_left--;
        case (mode)
          SINK_OPEN:     byte_ch.ready <= 1'b1;
          SINK_COIN:     byte_ch.ready <= 1'($urandom_range(0, 1));
          SINK_SPARSE:   byte_ch.ready <= ($urandom_range(0, 3) == 0);
          SINK_PERIODIC: byte_ch.ready <= (tick % 3 == 0);
          default:       byte_ch.ready <= 1'b1;
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // Request side.
  // --------------------------------------------------------------------------
  function automatic display_cmd_t make_cmd(logic [lmcfe_pkg::ACT_W-1:0]  action,
                                            logic [lmcfe_pkg::DEV_W-1:0]  device,
                                            logic [lmcfe_pkg::ROW_W-1:0]  row,
                                            logic [lmcfe_pkg::COL_W-1:0]  col,
                                            logic                         on,
                                            logic [lmcfe_pkg::BYTE_W-1:0] value);
    display_cmd_t c;
    c.action     = action;
    c.device     = device;
    c.row        = row;
    c.col        = col;
    c.pixel_on   = on;
    c.data_value = value;
    return c;
  endfunction

  // Most requests are well formed: a display in the chain and a row and column
  // on the panel, weighted toward pixel and row writes so that the shadow
  // builds up. About one in eight is noise over the whole of every field,
  // which covers displays off the chain, rows and columns past the panel and
  // the spare actions. Fields that an action does not use stay fully random.
  function automatic display_cmd_t random_command();
    display_cmd_t c;
    int           pick;
    c.action     = lmcfe_pkg::ACT_W'($urandom);
    c.device     = lmcfe_pkg::DEV_W'($urandom);
    c.row        = lmcfe_pkg::ROW_W'($urandom);
    c.col        = lmcfe_pkg::COL_W'($urandom);
    c.pixel_on   = 1'($urandom);
    c.data_value = lmcfe_pkg::BYTE_W'($urandom);
    pick = $urandom_range(0, 99);
    if (pick >= 12) begin
      c.device = lmcfe_pkg::DEV_W'($urandom_range(0, lmcfe_pkg::CHAIN_LENGTH - 1));
      c.row    = lmcfe_pkg::ROW_W'($urandom_range(0, lmcfe_pkg::ROWS - 1));
      pick     = $urandom_range(0, 99);
      if (pick < 50) begin
        c.action = lmcfe_pkg::ACT_SET_PIXEL;
        c.col    = lmcfe_pkg::COL_W'($urandom_range(0, COLS - 1));
      end else if (pick < 75) begin
        c.action = lmcfe_pkg::ACT_SET_ROW;
      end else if (pick < 85) begin
        c.action = lmcfe_pkg::ACT_INTENSITY;
      end else if (pick < 93) begin
        c.action = lmcfe_pkg::ACT_CLEAR_DEV;
      end else begin
        c.action = lmcfe_pkg::ACT_INIT;
      end
    end
    return c;
  endfunction

  // Offers one request and returns at the edge where it is taken. The sender
  // works in bursts; at the end of a burst it may drop valid for a random gap.
  // Valid is only ever lowered here or in drain_block, so it is never lowered
  // and raised again within one step.
  task automatic send_command(display_cmd_t c);
    int gap;
    cmd_ch.valid      <= 1'b1;
    cmd_ch.action     <= c.action;
    cmd_ch.device     <= c.device;
    cmd_ch.row        <= c.row;
    cmd_ch.col        <= c.col;
    cmd_ch.pixel_on   <= c.pixel_on;
    cmd_ch.data_value <= c.data_value;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 10);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        cmd_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Stops offering requests and waits until every owed byte has arrived,
  // then lets the block settle. Waiting on the clock first gives the monitor
  // time to note the last request before the queue is looked at.
  task automatic drain_block();
    cmd_ch.valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (tracker.owed_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_SLACK) @(posedge clk);
  endtask

  // The register is written only while the block is idle.
  task automatic write_active_devices(logic [lmcfe_pkg::CFG_W-1:0] count);
    cfg_we    <= 1'b1;
    cfg_wdata <= count;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Requests that change nothing do not count toward a phase's length.
  task automatic run_phase(logic [lmcfe_pkg::CFG_W-1:0] count, bit long_hold);
    display_cmd_t c;
    int           useful;
    useful = 0;
    write_active_devices(count);
    if (long_hold) hold_cycles_left = LONG_HOLD;
    // Each phase begins from a fresh init, as the panels would in use.
    c        = random_command();
    c.action = lmcfe_pkg::ACT_INIT;
    send_command(c);
    while (useful < PHASE_REQUESTS) begin
      c = random_command();
      if (tracker.yields_output(c)) useful++;
      send_command(c);
    end
    drain_block();
  endtask

  // --------------------------------------------------------------------------
  // Main sequence.
  // --------------------------------------------------------------------------
  initial begin
    display_cmd_t directed[$];
    tracker = new();

    rst_n             <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_wdata         <= '0;
    cmd_ch.valid      <= 1'b0;
    cmd_ch.action     <= '0;
    cmd_ch.device     <= '0;
    cmd_ch.row        <= '0;
    cmd_ch.col        <= '0;
    cmd_ch.pixel_on   <= 1'b0;
    cmd_ch.data_value <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, under the reset count of two displays. It starts with
    // init, the longest request. Then it covers pixel set on both edge columns,
    // pixel clear on column zero, a pixel set or cleared twice over, rows at both
    // ends, a clear followed by a pixel write, intensity at both extremes, every
    // per-display request on a display past the chain, rows and columns past
    // the panel, the spare actions, and a second init that must wipe the
    // shadow.
    directed.push_back(make_cmd(lmcfe_pkg::ACT_INIT,      2'd0, 4'd0,  4'd0,  1'b0, 8'h00));
    directed.push_back(make_cmd(lmcfe_pkg::ACT_SET_PIXEL, 2'd0, 4'd0,  4'd0,  1'b1, 8'h00));
    directed.push_back(make_cmd(lmcfe_pkg::ACT_SET_PIXEL, 2'd0, 4'd0,  4'd7,  1'b1, 8'hFF));
    directed.push_back(make_cmd(lmcfe_pkg::ACT_SET_PIXEL, 2'd0, 4'd0,  4'd0,  1'b0, 8'h00));
    directed.push_back(make_cmd(lmcfe_pkg::ACT_SET_PIXEL, 2'd0, 4'd0,  4'd0,  1'b0, 8'h00));
    directed.push_back(make_cmd(lmcfe_pkg::ACT_SET_PIXEL, 2'd1, 4'd7,  4'd7,  1'b1, 8'h00));
    directed.push_back(make_cmd(lmcfe_pkg::ACT_SET_PIXEL, 2'd1, 4'd7,  4'd7,  1'b1, 8'h00));
    directed.push_back(make_cmd(lmcfe_pkg::ACT_SET_ROW,   2'd1, 4'd3,  4'd0,  1'b0, 8'hFF));
    directed.push_back(make_cmd(lmcfe_pkg::ACT_SET_ROW,   2'd0, 4'd7,  4'd0,  1'b0, 8'h00));
    directed.push_back(make_cmd(lmcfe_pkg::ACT_SET_ROW,   2'd1, 4'd0,  4'd15, 1'b1, 8'hA5));
    directed.push_back(make_cmd(lmcfe_pkg::ACT_SET_PIXEL, 2'd1, 4'd0,  4'd2,  1'b0, 8'h00));
    directed.push_back(make_cmd(lmcfe_pkg::ACT_CLEAR_DEV, 2'd1, 4'd15, 4'd15, 1'b1, 8'hFF));
    directed.push_back(make_cmd(lmcfe_pkg::ACT_SET_PIXEL, 2'd1, 4'd3,  4'd4,  1'b1, 8'h00));
    directed.push_back(make_cmd(lmcfe_pkg::ACT_INTENSITY, 2'd0, 4'd0,  4'd0,  1'b0, 8'h00));
    directed.push_back(make_cmd(lmcfe_pkg::ACT_INTENSITY, 2'd1, 4'd0,  4'd0,  1'b0, 8'hFF));
    directed.push_back(make_cmd(lmcfe_pkg::ACT_SET_PIXEL, 2'd3, 4'd0,  4'd0,  1'b1, 8'h00));
    directed.push_back(make_cmd(lmcfe_pkg::ACT_SET_ROW,   2'd2, 4'd1,  4'd0,  1'b0, 8'h55));
    directed.push_back(make_cmd(lmcfe_pkg::ACT_CLEAR_DEV, 2'd3, 4'd0,  4'd0,  1'b0, 8'h00));
    directed.push_back(make_cmd(lmcfe_pkg::ACT_INTENSITY, 2'd2, 4'd0,  4'd0,  1'b0, 8'h7F));
    directed.push_back(make_cmd(lmcfe_pkg::ACT_SET_PIXEL, 2'd0, 4'd8,  4'd0,  1'b1, 8'h00));
    directed.push_back(make_cmd(lmcfe_pkg::ACT_SET_PIXEL, 2'd0, 4'd0,  4'd8,  1'b1, 8'h00));
    directed.push_back(make_cmd(lmcfe_pkg::ACT_SET_ROW,   2'd0, 4'd12, 4'd0,  1'b0, 8'hAA));
    directed.push_back(make_cmd(ACT_SPARE_A,              2'd0, 4'd0,  4'd0,  1'b1, 8'h12));
    directed.push_back(make_cmd(ACT_SPARE_B,              2'd1, 4'd1,  4'd1,  1'b0, 8'h34));
    directed.push_back(make_cmd(ACT_SPARE_C,              2'd1, 4'd2,  4'd2,  1'b1, 8'h56));
    directed.push_back(make_cmd(lmcfe_pkg::ACT_INIT,      2'd3, 4'd15, 4'd15, 1'b1, 8'hFF));
    directed.push_back(make_cmd(lmcfe_pkg::ACT_SET_PIXEL, 2'd1, 4'd7,  4'd0,  1'b1, 8'h00));
    foreach (directed[i]) send_command(directed[i]);
    drain_block();

    // Random phases. The count goes through one display, a value past the
    // chain length (clipped to it), zero (init only clears the shadow) and
    // back to the full chain. The last phase opens with the long hold.
    run_phase(2'd1, 1'b0);
    run_phase(2'd3, 1'b0);
    run_phase(2'd0, 1'b0);
    run_phase(2'd2, 1'b1);

    if (tracker.owed_bytes.size() != 0)
      tracker.report_mismatch($sformatf("%0d bytes never arrived",
                                        tracker.owed_bytes.size()));
    if (tracker.mismatch_count == 0) begin
      $display("led_matrix_chain_frame_engine regression: pass");
    end else begin
      $display("led_matrix_chain_frame_engine regression: fail");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/lmcfe_pkg.sv
rtl/lmcfe_in_if.sv
rtl/lmcfe_out_if.sv
rtl/lmcfe_row_store.sv
rtl/lmcfe_sequencer.sv
rtl/led_matrix_chain_frame_engine.sv
bench/testbench.sv
